// ===== src/character_block_queues_assert.svh =====
// Assertion macros shared by the character block queue RTL.
`ifndef CHARACTER_BLOCK_QUEUES_ASSERT_SVH
`define CHARACTER_BLOCK_QUEUES_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CBQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbq_pkg.sv =====
// Types and codes of the character block queues.
`timescale 1ns / 1ps

package cbq_pkg;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NO_BLOCK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

// ===== src/character_block_queues.sv =====
// Top level of the character block queues: byte FIFOs sharing a pool of linked blocks.
`timescale 1ns / 1ps
`include "character_block_queues_assert.svh"

// QUEUE_COUNT byte queues share BLOCK_COUNT blocks of BLOCK_BYTES bytes each.
// A request on the slave stream is either a put (append put_byte to the
// queue) or a get (remove the oldest byte). Each request gives exactly one
// response on the master stream: got_byte and a status (ok, get on an empty
// queue, or put with no free block). A request has an accept cycle and an
// update cycle: in the accept cycle the byte store and the link store are
// read at addresses taken from the queue's head position and the free list
// head; in the update cycle the registered read data is used to update the
// queue, the free list and the two stores, and the response is loaded into
// the output register. The split comes from the read-then-write of the
// shared stores. If the output register is still full and not being taken,
// the update cycle waits. Requests are taken one at a time; a new request
// is taken while a finished response still waits downstream. After reset
// every block is free, chained in order; no clearing pass is needed: link
// entries not yet written read as their reset chain value. A queue index
// of QUEUE_COUNT or more wraps modulo QUEUE_COUNT.
module character_block_queues
  import cbq_pkg::*;
#(
  parameter int BLOCK_COUNT = 64,   // 2 .. 1024
  parameter int QUEUE_COUNT = 4,    // 1 .. 4
  parameter int BLOCK_BYTES = 6     // 1 .. 62
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] put_byte
  input  logic [2:0] s_axis_tuser,   // [0] op, [2:1] queue_index
  // response stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] got_byte
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  localparam int POOL = BLOCK_COUNT * BLOCK_BYTES;
  localparam int BIW  = $clog2(BLOCK_COUNT);         // block index
  localparam int LW   = $clog2(BLOCK_COUNT + 1);     // link, incl. "none"
  localparam int OW   = $clog2(BLOCK_BYTES + 1);     // offset in block
  localparam int AW   = $clog2(POOL);                // byte store address
  localparam int CW   = $clog2(POOL + 1);            // byte count
  localparam int QIW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  localparam logic [LW-1:0] NO_BLOCK  = LW'(BLOCK_COUNT);
  localparam logic [OW-1:0] OFF_FULL  = OW'(BLOCK_BYTES);
  localparam logic [OW-1:0] OFF_LAST  = OW'(BLOCK_BYTES - 1);

  // Per-queue bookkeeping. Tail offset counts bytes in the tail block,
  // so it equals BLOCK_BYTES when that block is full.
  typedef struct packed {
    logic [BIW-1:0] head_blk;
    logic [OW-1:0]  head_off;
    logic [BIW-1:0] tail_blk;
    logic [OW-1:0]  tail_off;
    logic [CW-1:0]  count;
  } qrow_t;

  function automatic logic [QIW-1:0] queue_sel(input logic [1:0] idx);
    logic [2:0] v;
    v = {1'b0, idx};
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= QUEUE_COUNT) v = v - 3'(QUEUE_COUNT);
    end
    return QIW'(v);
  endfunction

  function automatic logic [AW-1:0] byte_addr(input logic [BIW-1:0] blk,
                                              input logic [OW-1:0] off);
    return AW'(AW'(blk) * AW'(BLOCK_BYTES) + AW'(off));
  endfunction

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_fire, exec_fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == ST_EXEC) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------
  qrow_t          qrow_q [QUEUE_COUNT];
  logic [LW-1:0]  free_head_q, free_head_d;
  logic [BLOCK_COUNT-1:0] link_vld_q;

  // Accept cycle: pick the queue, latch the request and its queue row.
  logic [QIW-1:0] qsel;
  qrow_t          row_in;
  logic [BIW-1:0] link_ra;
  logic [AW-1:0]  byte_ra;

  assign qsel    = queue_sel(s_axis_tuser[2:1]);
  assign row_in  = qrow_q[qsel];
  assign byte_ra = byte_addr(row_in.head_blk, row_in.head_off);

  // Put reads the link of the free head, get that of the head block.
  always_comb begin
    if (op_e'(s_axis_tuser[0]) == OP_PUT) begin
      link_ra = (free_head_q == NO_BLOCK) ? '0 : BIW'(free_head_q);
    end else begin
      link_ra = row_in.head_blk;
    end
  end

  op_e            op_q;
  logic [QIW-1:0] q_q;
  logic [7:0]     put_byte_q;
  qrow_t          row_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= op_e'(s_axis_tuser[0]);
      q_q        <= qsel;
      put_byte_q <= s_axis_tdata;
      row_q      <= row_in;
    end
  end

  // ---------------------------------------------------------------------
  // Byte store and link store
  // ---------------------------------------------------------------------
  logic [7:0]     byte_mem [POOL];
  logic [7:0]     byte_rd_q;
  logic           byte_we;
  logic [AW-1:0]  byte_wa;

  always_ff @(posedge clk_i) begin
    if (byte_we && exec_fire) byte_mem[byte_wa] <= put_byte_q;
    if (in_fire) byte_rd_q <= byte_mem[byte_ra];
  end

  logic [LW-1:0]  link_mem [BLOCK_COUNT];
  logic [LW-1:0]  link_rd_q, link_dflt_q, link_val;
  logic           link_rd_vld_q;
  logic           link_we;
  logic [BIW-1:0] link_wa;
  logic [LW-1:0]  link_wd;

  always_ff @(posedge clk_i) begin
    if (link_we && exec_fire) link_mem[link_wa] <= link_wd;
    if (in_fire) begin
      link_rd_q     <= link_mem[link_ra];
      link_rd_vld_q <= link_vld_q[link_ra];
      link_dflt_q   <= LW'(LW'(link_ra) + LW'(1));
    end
  end

  // Unwritten links hold the reset chain: block i points at i + 1.
  assign link_val = link_rd_vld_q ? link_rd_q : link_dflt_q;

  // ---------------------------------------------------------------------
  // Update cycle
  // ---------------------------------------------------------------------
  qrow_t      row_d;
  logic [7:0] got_d;
  status_e    status_d;

  always_comb begin
    row_d       = row_q;
    free_head_d = free_head_q;
    got_d       = '0;
    status_d    = STATUS_OK;
    byte_we     = 1'b0;
    byte_wa     = byte_addr(row_q.tail_blk, row_q.tail_off);
    link_we     = 1'b0;
    link_wa     = row_q.head_blk;
    link_wd     = free_head_q;

    if (op_q == OP_PUT) begin
      if (row_q.count == '0) begin
        // empty queue: first block from the free list
        if (free_head_q == NO_BLOCK) begin
          status_d = STATUS_NO_BLOCK;
        end else begin
          free_head_d    = link_val;
          row_d.head_blk = BIW'(free_head_q);
          row_d.head_off = '0;
          row_d.tail_blk = BIW'(free_head_q);
          row_d.tail_off = OW'(1);
          row_d.count    = CW'(1);
          byte_we        = 1'b1;
          byte_wa        = byte_addr(BIW'(free_head_q), '0);
        end
      end else if (row_q.tail_off == OFF_FULL) begin
        // tail block full: chain a fresh block behind it
        if (free_head_q == NO_BLOCK) begin
          status_d = STATUS_NO_BLOCK;
        end else begin
          free_head_d    = link_val;
          link_we        = 1'b1;
          link_wa        = row_q.tail_blk;
          link_wd        = free_head_q;
          row_d.tail_blk = BIW'(free_head_q);
          row_d.tail_off = OW'(1);
          row_d.count    = CW'(row_q.count + CW'(1));
          byte_we        = 1'b1;
          byte_wa        = byte_addr(BIW'(free_head_q), '0);
        end
      end else begin
        row_d.tail_off = OW'(row_q.tail_off + OW'(1));
        row_d.count    = CW'(row_q.count + CW'(1));
        byte_we        = 1'b1;
      end
    end else begin
      if (row_q.count == '0) begin
        status_d = STATUS_EMPTY;
      end else begin
        got_d       = byte_rd_q;
        row_d.count = CW'(row_q.count - CW'(1));
        if (row_q.count == CW'(1)) begin
          // last byte: head block goes back to the free list
          link_we        = 1'b1;
          free_head_d    = LW'(row_q.head_blk);
          row_d.head_blk = '0;
          row_d.head_off = '0;
          row_d.tail_blk = '0;
          row_d.tail_off = '0;
        end else if (row_q.head_off == OFF_LAST) begin
          // head block drained: follow its link, free it
          link_we        = 1'b1;
          free_head_d    = LW'(row_q.head_blk);
          row_d.head_blk = BIW'(link_val);
          row_d.head_off = '0;
        end else begin
          row_d.head_off = OW'(row_q.head_off + OW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      link_vld_q  <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        qrow_q[i] <= '0;
      end
    end else if (exec_fire) begin
      free_head_q <= free_head_d;
      qrow_q[q_q] <= row_d;
      if (link_we) link_vld_q[link_wa] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------
  logic       out_valid_q;
  logic [7:0] got_q;
  status_e    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      got_q    <= got_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = got_q;
  assign m_axis_tuser  = status_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `CBQ_ASSERT_NXT(a_accept_then_update, in_fire, state_q == ST_EXEC,
    "request accepted without an update cycle")
  `CBQ_ASSERT_NXT(a_update_loads_response, exec_fire, m_axis_tvalid,
    "update cycle left no response")
  `CBQ_ASSERT_IMP(a_no_block_only_if_list_empty,
    exec_fire && (status_d == STATUS_NO_BLOCK), free_head_q == NO_BLOCK,
    "put refused while a block was free")
  `CBQ_ASSERT_IMP(a_get_writes_no_byte, exec_fire && (op_q == OP_GET), !byte_we,
    "get wrote the byte store")

endmodule
